// File: hw/rtl/tmss_pkg.sv
// Shared types and codes for the TWI master/slave sequencer.
// No dependencies.
`default_nettype none
package tmss_pkg;
   localparam int BufferDepth = 32;

   localparam logic [2:0] MODE_LOAD  = 3'd0;
   localparam logic [2:0] MODE_WRITE = 3'd1;
   localparam logic [2:0] MODE_READ  = 3'd2;
   localparam logic [2:0] MODE_EVENT = 3'd3;
   localparam logic [2:0] MODE_POP   = 3'd4;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_ACK     = 3'd2;
   localparam logic [2:0] ACT_NACK    = 3'd3;
   localparam logic [2:0] ACT_STOP    = 3'd4;
   localparam logic [2:0] ACT_RELEASE = 3'd5;

   localparam logic [2:0] BM_READY = 3'd0;
   localparam logic [2:0] BM_MTX   = 3'd1;
   localparam logic [2:0] BM_MRX   = 3'd2;
   localparam logic [2:0] BM_STX   = 3'd3;
   localparam logic [2:0] BM_SRX   = 3'd4;

   localparam logic [2:0] WR_OK       = 3'd0;
   localparam logic [2:0] WR_TOO_LONG = 3'd1;
   localparam logic [2:0] WR_ADDR_NACK = 3'd2;
   localparam logic [2:0] WR_DATA_NACK = 3'd3;
   localparam logic [2:0] WR_OTHER    = 3'd4;

   localparam logic [7:0] NO_ERROR = 8'hFF;

   // bus status codes, prescaler bits masked
   localparam logic [7:0] EV_BUS_FAULT         = 8'h00;
   localparam logic [7:0] EV_START_DONE        = 8'h08;
   localparam logic [7:0] EV_RESTART_DONE      = 8'h10;
   localparam logic [7:0] EV_WADDR_ACKED       = 8'h18;
   localparam logic [7:0] EV_WADDR_REFUSED     = 8'h20;
   localparam logic [7:0] EV_WBYTE_ACKED       = 8'h28;
   localparam logic [7:0] EV_WBYTE_REFUSED     = 8'h30;
   localparam logic [7:0] EV_ARB_LOST          = 8'h38;
   localparam logic [7:0] EV_RADDR_ACKED       = 8'h40;
   localparam logic [7:0] EV_RADDR_REFUSED     = 8'h48;
   localparam logic [7:0] EV_RBYTE_ACKED       = 8'h50;
   localparam logic [7:0] EV_RBYTE_LAST        = 8'h58;
   localparam logic [7:0] EV_SR_ADDR           = 8'h60;
   localparam logic [7:0] EV_SR_ARB_ADDR       = 8'h68;
   localparam logic [7:0] EV_SR_BCAST          = 8'h70;
   localparam logic [7:0] EV_SR_ARB_BCAST      = 8'h78;
   localparam logic [7:0] EV_SR_BYTE           = 8'h80;
   localparam logic [7:0] EV_SR_BYTE_REFUSED   = 8'h88;
   localparam logic [7:0] EV_SR_BCAST_BYTE     = 8'h90;
   localparam logic [7:0] EV_SR_BCAST_REFUSED  = 8'h98;
   localparam logic [7:0] EV_SR_END            = 8'hA0;
   localparam logic [7:0] EV_ST_ADDR           = 8'hA8;
   localparam logic [7:0] EV_ST_ARB_ADDR       = 8'hB0;
   localparam logic [7:0] EV_ST_BYTE           = 8'hB8;
   localparam logic [7:0] EV_ST_BYTE_REFUSED   = 8'hC0;
   localparam logic [7:0] EV_ST_LAST_BYTE      = 8'hC8;

   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] address;
      logic [5:0] length;
      logic [7:0] data_in;
      logic [7:0] status_code;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_out;
      logic       data_out_valid;
      logic [7:0] rx_byte;
      logic [5:0] bytes_available;
      logic [2:0] bus_state;
      logic [2:0] write_result;
      logic       done_res;
      logic       receive_event;
      logic       transmit_event;
      logic       reject;
   } rsp_type;
endpackage
`default_nettype wire

// File: hw/rtl/twi_master_slave_sequencer_top.sv
// Top level of the TWI master/slave sequencer: front queue plus execution back end.
// Response valid is registered: an accepted request beat is written into the queue,
// then executed into the response register. Throughput: one item per cycle;
// a stalled response lets the two-entry queue fill, then req_stall rises.
// Reset: synchronous, active high; bus ready, no error, buffers empty.
// Depends on tmss_pkg, tmss_front, tmss_back, tmss_ram.
`default_nettype none
module twi_master_slave_sequencer_top #(
   parameter int BufferDepth = tmss_pkg::BufferDepth
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [2:0]  req_mode,
   input  wire [6:0]  req_address,
   input  wire [5:0]  req_length,
   input  wire [7:0]  req_data_in,
   input  wire [7:0]  req_status_code,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_data_out,
   output logic       rsp_data_out_valid,
   output logic [7:0] rsp_rx_byte,
   output logic [5:0] rsp_bytes_available,
   output logic [2:0] rsp_bus_state,
   output logic [2:0] rsp_write_result,
   output logic       rsp_done_res,
   output logic       rsp_receive_event,
   output logic       rsp_transmit_event,
   output logic       rsp_reject
);
   tmss_pkg::req_type in_item, q_item;
   tmss_pkg::rsp_type r;
   logic q_valid, q_pop;

   assign in_item = '{mode: req_mode, address: req_address, length: req_length,
                      data_in: req_data_in, status_code: req_status_code};

   tmss_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_item(in_item), .out_valid(q_valid), .out_pop(q_pop), .out_item(q_item));

   tmss_back #(.BufferDepth(BufferDepth)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_pop(q_pop),
      .in_item(q_item), .out_valid(rsp_valid), .out_stall(rsp_stall), .out_item(r));

   assign rsp_action = r.action;
   assign rsp_data_out = r.data_out;
   assign rsp_data_out_valid = r.data_out_valid;
   assign rsp_rx_byte = r.rx_byte;
   assign rsp_bytes_available = r.bytes_available;
   assign rsp_bus_state = r.bus_state;
   assign rsp_write_result = r.write_result;
   assign rsp_done_res = r.done_res;
   assign rsp_receive_event = r.receive_event;
   assign rsp_transmit_event = r.transmit_event;
   assign rsp_reject = r.reject;
endmodule
`default_nettype wire

// File: hw/rtl/tmss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmss_ram #(
   parameter int Width = 8,
   parameter int Depth = 32,
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [AW-1:0]            wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [AW-1:0]            rd_addr,
   output logic [Width-1:0]        rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/tmss_front.sv
// Front end: queue of input beats toward the sequencer.
// Depends on tmss_pkg.
`default_nettype none
module tmss_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_stall,
   input  wire tmss_pkg::req_type in_item,
   output logic                  out_valid,
   input  wire                   out_pop,
   output tmss_pkg::req_type     out_item
);
   // two-entry queue
   tmss_pkg::req_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rp_ff, rp_in, wp_ff, wp_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign pop       = out_pop && (cnt_ff != 2'd0);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rp_in  = rp_ff ^ pop;
      wp_in  = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push) begin
         q_ff[wp_ff] <= in_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !out_valid) else $error("valid while empty");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2) else $error("full queue lost entry");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/tmss_back.sv
// Back end: executes queued items against the bus state, buffers and RAMs.
// Depends on tmss_pkg and tmss_ram.
`default_nettype none
module tmss_back #(
   parameter int BufferDepth = tmss_pkg::BufferDepth
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_pop,
   input  wire tmss_pkg::req_type in_item,
   output logic                   out_valid,
   input  wire                    out_stall,
   output tmss_pkg::rsp_type      out_item
);
   localparam int AW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
   localparam logic [8:0] DEPTH = 9'(BufferDepth);

   logic [2:0] bus_mode_ff, bus_mode_in;
   logic [7:0] last_error_ff, last_error_in;
   logic [7:0] arw_ff, arw_in;
   logic [8:0] tx_count_ff, tx_count_in, tx_pos_ff, tx_pos_in;
   logic [8:0] rx_exp_ff, rx_exp_in, rx_fill_ff, rx_fill_in, rx_rp_ff, rx_rp_in;
   logic       busy_ff, busy_in;

   // response register; tx/rx bytes come from the RAM read registers, loaded at the same edge
   logic              rv_ff;
   tmss_pkg::rsp_type r_ff, r_in;
   logic              tx_sel_ff, tx_sel_in, rx_sel_ff, rx_sel_in;
   logic              tx_rd_ok_ff, tx_rd_ok_in;

   logic            tx_we, rx_we, tx_re, rx_re;
   logic [AW-1:0]   tx_wa, rx_wa, tx_ra, rx_ra;
   logic [7:0]      tx_wd, rx_wd, tx_rd, rx_rd;
   logic            go;

   tmss_ram #(.Width(8), .Depth(BufferDepth)) u_tx (
      .clock(clock), .wr_en(tx_we), .wr_addr(tx_wa), .wr_data(tx_wd),
      .rd_en(tx_re), .rd_addr(tx_ra), .rd_data(tx_rd));
   tmss_ram #(.Width(8), .Depth(BufferDepth)) u_rx (
      .clock(clock), .wr_en(rx_we), .wr_addr(rx_wa), .wr_data(rx_wd),
      .rd_en(rx_re), .rd_addr(rx_ra), .rd_data(rx_rd));

   assign go     = in_valid && (!rv_ff || !out_stall);
   assign in_pop = go;
   assign out_valid = rv_ff;

   always_comb begin
      out_item = r_ff;
      if (tx_sel_ff) out_item.data_out = tx_rd_ok_ff ? tx_rd : 8'h00;
      if (rx_sel_ff) out_item.rx_byte = rx_rd;
   end

   always_comb begin
      logic stopping, finish;
      logic [7:0] code;
      logic [8:0] fill_put;
      logic [8:0] st_cnt, st_pos;
      bus_mode_in = bus_mode_ff; last_error_in = last_error_ff; arw_in = arw_ff;
      tx_count_in = tx_count_ff; tx_pos_in = tx_pos_ff; rx_exp_in = rx_exp_ff;
      rx_fill_in = rx_fill_ff; rx_rp_in = rx_rp_ff; busy_in = busy_ff;
      r_in = '0; tx_sel_in = 1'b0; rx_sel_in = 1'b0; tx_rd_ok_in = 1'b0;
      tx_we = 1'b0; rx_we = 1'b0; tx_re = 1'b0; rx_re = 1'b0;
      tx_wa = tx_count_ff[AW-1:0]; tx_wd = in_item.data_in;
      rx_wa = rx_fill_ff[AW-1:0]; rx_wd = in_item.data_in;
      tx_ra = tx_pos_ff[AW-1:0]; rx_ra = rx_rp_ff[AW-1:0];
      stopping = 1'b0; finish = 1'b0;
      code = in_item.status_code;
      fill_put = rx_fill_ff;
      st_cnt = tx_count_ff; st_pos = tx_pos_ff;
      r_in.action = tmss_pkg::ACT_NONE;
      unique case (in_item.mode)
         tmss_pkg::MODE_LOAD: begin
            if (busy_ff || (bus_mode_ff != tmss_pkg::BM_READY &&
                bus_mode_ff != tmss_pkg::BM_STX) || tx_count_ff >= DEPTH) begin
               r_in.reject = 1'b1;
            end else begin
               tx_we = 1'b1;
               tx_count_in = tx_count_ff + 9'd1;
               tx_pos_in = 9'd0;
            end
         end
         tmss_pkg::MODE_WRITE, tmss_pkg::MODE_READ: begin
            if ({3'd0, in_item.length} > DEPTH) begin
               r_in.reject = 1'b1; r_in.write_result = tmss_pkg::WR_TOO_LONG;
            end else if (busy_ff || bus_mode_ff != tmss_pkg::BM_READY) begin
               r_in.reject = 1'b1; r_in.write_result = tmss_pkg::WR_OTHER;
            end else begin
               last_error_in = tmss_pkg::NO_ERROR;
               if (in_item.mode == tmss_pkg::MODE_WRITE) begin
                  tx_pos_in = 9'd0; tx_count_in = {3'd0, in_item.length};
                  arw_in = {in_item.address, 1'b0};
               end else begin
                  rx_fill_in = 9'd0; rx_rp_in = 9'd0;
                  rx_exp_in = {3'd0, in_item.length};
                  arw_in = {in_item.address, 1'b1};
               end
               busy_in = 1'b1;
               r_in.action = tmss_pkg::ACT_START;
            end
         end
         tmss_pkg::MODE_EVENT: begin
            unique case (code)
               tmss_pkg::EV_START_DONE, tmss_pkg::EV_RESTART_DONE: begin
                  r_in.data_out = arw_ff; r_in.data_out_valid = 1'b1;
                  r_in.action = tmss_pkg::ACT_ACK;
               end
               tmss_pkg::EV_WADDR_ACKED, tmss_pkg::EV_WBYTE_ACKED: begin
                  if (code == tmss_pkg::EV_WADDR_ACKED) bus_mode_in = tmss_pkg::BM_MTX;
                  if (tx_pos_ff < tx_count_ff) begin
                     tx_re = 1'b1; tx_sel_in = 1'b1;
                     tx_rd_ok_in = tx_pos_ff < DEPTH;
                     r_in.data_out_valid = 1'b1;
                     tx_pos_in = tx_pos_ff + 9'd1;
                     r_in.action = tmss_pkg::ACT_ACK;
                  end else begin
                     r_in.action = tmss_pkg::ACT_STOP; stopping = 1'b1;
                  end
               end
               tmss_pkg::EV_WADDR_REFUSED, tmss_pkg::EV_WBYTE_REFUSED: begin
                  last_error_in = code; r_in.action = tmss_pkg::ACT_STOP;
                  stopping = 1'b1;
               end
               tmss_pkg::EV_ARB_LOST: begin
                  last_error_in = code; r_in.action = tmss_pkg::ACT_RELEASE;
                  stopping = 1'b1;
               end
               tmss_pkg::EV_RADDR_ACKED, tmss_pkg::EV_RBYTE_ACKED: begin
                  if (code == tmss_pkg::EV_RADDR_ACKED) bus_mode_in = tmss_pkg::BM_MRX;
                  else if (rx_fill_ff < DEPTH) begin
                     rx_we = 1'b1; fill_put = rx_fill_ff + 9'd1;
                  end
                  rx_fill_in = fill_put;
                  r_in.action = (fill_put + 9'd1 < rx_exp_ff) ?
                                tmss_pkg::ACT_ACK : tmss_pkg::ACT_NACK;
               end
               tmss_pkg::EV_RBYTE_LAST, tmss_pkg::EV_RADDR_REFUSED: begin
                  if (code == tmss_pkg::EV_RBYTE_LAST && rx_fill_ff < DEPTH) begin
                     rx_we = 1'b1; rx_fill_in = rx_fill_ff + 9'd1;
                  end
                  r_in.action = tmss_pkg::ACT_STOP; stopping = 1'b1;
               end
               tmss_pkg::EV_SR_ADDR, tmss_pkg::EV_SR_ARB_ADDR, tmss_pkg::EV_SR_BCAST,
               tmss_pkg::EV_SR_ARB_BCAST: begin
                  if ((code == tmss_pkg::EV_SR_ARB_ADDR ||
                       code == tmss_pkg::EV_SR_ARB_BCAST) && busy_ff) begin
                     last_error_in = tmss_pkg::EV_ARB_LOST; finish = 1'b1;
                  end
                  bus_mode_in = tmss_pkg::BM_SRX;
                  rx_fill_in = 9'd0; rx_rp_in = 9'd0;
                  r_in.action = tmss_pkg::ACT_ACK;
               end
               tmss_pkg::EV_SR_BYTE, tmss_pkg::EV_SR_BCAST_BYTE: begin
                  if (rx_fill_ff < DEPTH) begin
                     rx_we = 1'b1; rx_fill_in = rx_fill_ff + 9'd1;
                     r_in.action = tmss_pkg::ACT_ACK;
                  end else r_in.action = tmss_pkg::ACT_NACK;
               end
               tmss_pkg::EV_SR_END: begin
                  r_in.receive_event = 1'b1; r_in.action = tmss_pkg::ACT_RELEASE;
                  stopping = 1'b1;
               end
               tmss_pkg::EV_SR_BYTE_REFUSED, tmss_pkg::EV_SR_BCAST_REFUSED:
                  r_in.action = tmss_pkg::ACT_NACK;
               tmss_pkg::EV_ST_ADDR, tmss_pkg::EV_ST_ARB_ADDR, tmss_pkg::EV_ST_BYTE: begin
                  if (code == tmss_pkg::EV_ST_ARB_ADDR && busy_ff) begin
                     last_error_in = tmss_pkg::EV_ARB_LOST; finish = 1'b1;
                  end
                  if (code != tmss_pkg::EV_ST_BYTE) bus_mode_in = tmss_pkg::BM_STX;
                  // a master write lost here drops its tx bytes before the slave reads
                  if (finish && !arw_ff[0]) begin
                     st_cnt = 9'd0; st_pos = 9'd0;
                  end
                  r_in.transmit_event = 1'b1; r_in.data_out_valid = 1'b1;
                  if (st_pos < st_cnt) begin
                     tx_re = 1'b1; tx_sel_in = 1'b1;
                     tx_rd_ok_in = st_pos < DEPTH;
                     tx_pos_in = st_pos + 9'd1;
                  end
                  r_in.action = (tx_pos_in < st_cnt) ?
                                tmss_pkg::ACT_ACK : tmss_pkg::ACT_NACK;
               end
               tmss_pkg::EV_ST_BYTE_REFUSED, tmss_pkg::EV_ST_LAST_BYTE: begin
                  r_in.action = tmss_pkg::ACT_ACK; bus_mode_in = tmss_pkg::BM_READY;
                  tx_count_in = 9'd0; tx_pos_in = 9'd0;
               end
               tmss_pkg::EV_BUS_FAULT: begin
                  last_error_in = tmss_pkg::EV_BUS_FAULT; r_in.action = tmss_pkg::ACT_STOP;
                  stopping = 1'b1;
               end
               default: ;
            endcase
            if (stopping) begin
               bus_mode_in = tmss_pkg::BM_READY;
               finish = busy_ff;
            end
            // end the master transfer; a write reports its result and drops tx
            if (finish) begin
               busy_in = 1'b0; r_in.done_res = 1'b1;
               if (!arw_ff[0]) begin
                  tx_count_in = 9'd0; tx_pos_in = 9'd0;
                  if (last_error_in == tmss_pkg::NO_ERROR)
                     r_in.write_result = tmss_pkg::WR_OK;
                  else if (last_error_in == tmss_pkg::EV_WADDR_REFUSED)
                     r_in.write_result = tmss_pkg::WR_ADDR_NACK;
                  else if (last_error_in == tmss_pkg::EV_WBYTE_REFUSED)
                     r_in.write_result = tmss_pkg::WR_DATA_NACK;
                  else r_in.write_result = tmss_pkg::WR_OTHER;
               end
            end
         end
         tmss_pkg::MODE_POP: begin
            if (rx_rp_ff < rx_fill_ff && rx_rp_ff < DEPTH) begin
               rx_re = 1'b1; rx_sel_in = 1'b1;
               rx_rp_in = rx_rp_ff + 9'd1;
            end
         end
         default: ;
      endcase
      r_in.bytes_available = (rx_fill_in >= rx_rp_in) ? 6'(rx_fill_in - rx_rp_in) : 6'd0;
      r_in.bus_state = bus_mode_in;
      if (!go) begin
         tx_we = 1'b0; rx_we = 1'b0; tx_re = 1'b0; rx_re = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff <= tmss_pkg::BM_READY; last_error_ff <= tmss_pkg::NO_ERROR;
         arw_ff <= 8'd0; tx_count_ff <= 9'd0; tx_pos_ff <= 9'd0;
         rx_exp_ff <= 9'd0; rx_fill_ff <= 9'd0; rx_rp_ff <= 9'd0;
         busy_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         if (go) begin
            bus_mode_ff <= bus_mode_in; last_error_ff <= last_error_in;
            arw_ff <= arw_in; tx_count_ff <= tx_count_in; tx_pos_ff <= tx_pos_in;
            rx_exp_ff <= rx_exp_in; rx_fill_ff <= rx_fill_in; rx_rp_ff <= rx_rp_in;
            busy_ff <= busy_in;
            rv_ff <= 1'b1;
         end else if (!out_stall) begin
            rv_ff <= 1'b0;
         end
      end
      if (go) begin
         r_ff <= r_in; tx_sel_ff <= tx_sel_in; rx_sel_ff <= rx_sel_in;
         tx_rd_ok_ff <= tx_rd_ok_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rx_fill_ff <= DEPTH) else $error("rx fill past depth");
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      rx_rp_ff <= rx_fill_ff || rx_rp_ff == 9'd0) else $error("rx read past fill");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && out_stall) |=> rv_ff && $stable(r_ff)) else $error("result lost");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (go && r_in.action == tmss_pkg::ACT_START) |=> busy_ff)
      else $error("start without busy");
`endif
endmodule
`default_nettype wire
